>>> hw/rtl/bba_pkg.sv
package bba_pkg;

    // Default geometry of the pool.
    localparam int LEVELS_DEF     = 8;
    localparam int TOP_BLOCKS_DEF = 4;
    localparam int MAX_LEVELS     = 12;
    localparam int QUEUE_DEPTH    = 2;

    // The free map is kept in rows of this many node bits.
    localparam int ROW_W    = 32;
    localparam int ROW_LOG2 = 5;

    // Field widths.
    localparam int SIZE_W     = 20;
    localparam int OFFSET_W   = 21;
    localparam int MBL_W      = 4;
    localparam int HDR_W      = 8;
    localparam int RLVL_W     = 3;
    localparam int LVL_W      = 4;
    localparam int NODE_IDX_W = 15;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MBL_W-1:0] MBL_RESET = 4'd5;
    localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NO_MEM    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_BLOCK_LOG2 = 1'b0,
        CFG_HEADER_BYTES   = 1'b1
    } cfg_idx_t;

    // Request word.
    typedef struct packed {
        op_t                 op;
        logic [SIZE_W-1:0]   size_bytes;
        logic [OFFSET_W-1:0] data_offset;
    } bba_req_t;

    // Result word.
    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] result_offset;
        logic [RLVL_W-1:0]   result_level;
    } bba_rsp_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                   op;
        logic                  reject;
        status_t               status;
        logic [LVL_W-1:0]      lvl;
        logic [NODE_IDX_W-1:0] node;
    } bba_cmd_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_A_RD,
        BK_A_CHK,
        BK_A_SPLIT_RD,
        BK_A_SPLIT_WR,
        BK_F_UP_RD,
        BK_F_UP_CHK,
        BK_F_CLR_RD,
        BK_F_CLR_WR,
        BK_F_MRG_RD,
        BK_F_MRG_CHK,
        BK_F_SET_RD,
        BK_F_SET_WR
    } back_state_t;

    // Number of map rows that hold one level.
    function automatic int level_rows(int levels, int top, int lvl);
        return ((top << (levels - 1 - lvl)) + ROW_W - 1) >> ROW_LOG2;
    endfunction

    // First map row of a level; levels are stored bottom up.
    function automatic int row_base(int levels, int top, int lvl);
        int b;
        b = 0;
        for (int j = 0; j < MAX_LEVELS; j++)
        begin
            if (j < lvl && j < levels)
            begin
                b = b + level_rows(levels, top, j);
            end
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/bba_ram.sv
module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = ROW_W,
    parameter int DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/bba_front.sv
module bba_front
    import bba_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int TOP_BLOCKS = TOP_BLOCKS_DEF
)
(
    input  bba_req_t         req,
    input  logic [MBL_W-1:0] min_block_log2,
    input  logic [HDR_W-1:0] header_bytes,
    output bba_cmd_t         cmd
);

    logic [OFFSET_W-1:0] need;
    logic [OFFSET_W-1:0] need_m1;
    logic [4:0]          ceil_log2;
    logic [4:0]          lvl_full;
    logic [4:0]          shamt;
    logic [OFFSET_W-1:0] start_off;
    logic [31:0]         align_mask;
    logic [39:0]         pool_bytes;
    logic [OFFSET_W-1:0] node_full;
    logic                hdr_ok;
    logic                aligned;
    logic                in_pool;

    // Size to level: round size plus header up to a power of two.
    always_comb
    begin
        need    = OFFSET_W'(req.size_bytes) + OFFSET_W'(header_bytes);
        need_m1 = need - OFFSET_W'(1);
        ceil_log2 = '0;
        for (int i = 0; i < OFFSET_W; i++)
        begin
            if (need_m1[i])
            begin
                ceil_log2 = 5'(i + 1);
            end
        end
        lvl_full = (ceil_log2 > {1'b0, min_block_log2}) ?
                   ceil_log2 - {1'b0, min_block_log2} : '0;
    end

    // Checks on the block named by a free.
    always_comb
    begin
        hdr_ok     = req.data_offset >= OFFSET_W'(header_bytes);
        start_off  = req.data_offset - OFFSET_W'(header_bytes);
        shamt      = {1'b0, min_block_log2} + lvl_full;
        align_mask = ~(32'hFFFF_FFFF << shamt);
        aligned    = (32'(start_off) & align_mask) == 32'd0;
        pool_bytes = 40'(TOP_BLOCKS) << ({1'b0, min_block_log2} + 5'(LEVELS - 1));
        in_pool    = 40'(start_off) < pool_bytes;
        node_full  = start_off >> shamt;
    end

    // Classification into a command for the back end.
    always_comb
    begin
        cmd.op     = req.op;
        cmd.reject = 1'b0;
        cmd.status = ST_OK;
        cmd.lvl    = LVL_W'(lvl_full);
        cmd.node   = NODE_IDX_W'(node_full);
        if (req.size_bytes == '0)
        begin
            cmd.reject = 1'b1;
            cmd.status = ST_ZERO;
            cmd.lvl    = '0;
        end
        else if (lvl_full > 5'(LEVELS - 1))
        begin
            cmd.reject = 1'b1;
            cmd.status = ST_TOO_LARGE;
            cmd.lvl    = '0;
        end
        else if (req.op == OP_FREE && !(hdr_ok && aligned && in_pool))
        begin
            cmd.reject = 1'b1;
            cmd.status = ST_TOO_LARGE;
            cmd.lvl    = '0;
        end
    end

endmodule

>>> hw/rtl/bba_queue.sv
module bba_queue
    import bba_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bba_cmd_t din,
    input  logic     pop,
    output bba_cmd_t dout,
    output logic     full,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bba_cmd_t        entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = count_reg == (PW + 1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign dout    = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> hw/rtl/bba_back.sv
module bba_back
    import bba_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int TOP_BLOCKS = TOP_BLOCKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  bba_cmd_t         q_head,
    output logic             q_pop,
    input  logic [MBL_W-1:0] min_block_log2,
    input  logic [HDR_W-1:0] header_bytes,
    output logic             clearing,
    output logic             done,
    output bba_rsp_t         rsp
);

    localparam int C0      = TOP_BLOCKS << (LEVELS - 1);
    localparam int GW      = $clog2(C0);
    localparam int LW      = $clog2(LEVELS);
    localparam int RIW     = (GW > ROW_LOG2) ? GW - ROW_LOG2 : 1;
    localparam int GXW     = GW + ROW_LOG2;
    localparam int SPW     = GXW + 1;
    localparam int SHW     = GW + 32;
    localparam int DEPTH   = row_base(LEVELS, TOP_BLOCKS, LEVELS);
    localparam int AW      = $clog2(DEPTH);
    localparam int TOP_ROW = row_base(LEVELS, TOP_BLOCKS, LEVELS - 1);
    localparam logic [ROW_W-1:0] TOP_ONES = ROW_W'((64'd1 << TOP_BLOCKS) - 64'd1);

    function automatic logic [RIW-1:0] row_of(logic [GW-1:0] x);
        logic [GXW-1:0] gx;
        gx = GXW'(x);
        return RIW'(gx >> ROW_LOG2);
    endfunction

    function automatic logic [ROW_LOG2-1:0] bit_of(logic [GW-1:0] x);
        logic [GXW-1:0] gx;
        gx = GXW'(x);
        return gx[ROW_LOG2-1:0];
    endfunction

    back_state_t      state_reg, state_next;
    bba_cmd_t         cmd_reg, cmd_next;
    logic [LW-1:0]    k_reg, k_next;
    logic [RIW-1:0]   row_reg, row_next;
    logic [GW-1:0]    g_reg, g_next;
    logic [GW-1:0]    w_reg, w_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    addr_reg;
    logic             done_reg, done_next;
    bba_rsp_t         rsp_reg, rsp_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ROW_W-1:0] rdata;
    logic [RIW-1:0]   rd_row;

    logic [LW-1:0]       lvl;
    logic [RIW-1:0]      last_row;
    logic [ROW_LOG2-1:0] pe;
    logic [GW-1:0]       g_found;
    logic [GW-1:0]       fin_g;
    logic [SHW-1:0]      blk_start;
    logic [OFFSET_W-1:0] alloc_off;
    logic [LW-1:0]       sh_k, sh_n, n_lvl;
    logic [SPW-1:0]      lo_k, hi_k, lo_n;
    logic [ROW_W-1:0]    clr_mask;
    logic [SPW-1:0]      pos;

    assign lvl      = LW'(cmd_reg.lvl);
    assign clearing = state_reg == BK_CLEAR;
    assign done     = done_reg;
    assign rsp      = rsp_reg;

    bba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Map addressing: every read is at the current level.
    assign ram_raddr = AW'(row_base(LEVELS, TOP_BLOCKS, int'(k_reg))) + AW'(rd_row);
    assign ram_waddr = (state_reg == BK_CLEAR) ? clr_reg : addr_reg;
    assign last_row  = RIW'(level_rows(LEVELS, TOP_BLOCKS, int'(k_reg)) - 1);

    // Lowest free node in the row just read, and the data offset it gives.
    always_comb
    begin
        pe = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (rdata[i])
            begin
                pe = ROW_LOG2'(i);
            end
        end
        g_found   = GW'((GXW'(row_reg) << ROW_LOG2) | GXW'(pe));
        fin_g     = (state_reg == BK_A_CHK) ? g_found : g_reg;
        blk_start = SHW'(fin_g) << ({1'b0, min_block_log2} + 5'(lvl));
        alloc_off = OFFSET_W'(blk_start + SHW'(header_bytes));
    end

    // Node range covered by the freed block at the level being cleared.
    always_comb
    begin
        n_lvl = (state_reg == BK_F_UP_CHK) ? '0 : k_reg + LW'(1);
        sh_k  = lvl - k_reg;
        sh_n  = lvl - n_lvl;
        lo_k  = SPW'(g_reg) << sh_k;
        hi_k  = (SPW'(g_reg) + SPW'(1)) << sh_k;
        lo_n  = SPW'(g_reg) << sh_n;
        for (int i = 0; i < ROW_W; i++)
        begin
            pos         = SPW'({row_reg, ROW_LOG2'(i)});
            clr_mask[i] = (pos >= lo_k) && (pos < hi_k);
        end
    end

    // Sequencer over the free map.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        g_next     = g_reg;
        w_next     = w_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = '0;
        rd_row     = row_reg;

        case (state_reg)
            BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (clr_reg == AW'(TOP_ROW)) ? TOP_ONES : '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end

            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    k_next   = LW'(q_head.lvl);
                    g_next   = GW'(q_head.node);
                    w_next   = GW'(q_head.node);
                    row_next = '0;
                    if (q_head.reject)
                    begin
                        done_next              = 1'b1;
                        rsp_next.status        = q_head.status;
                        rsp_next.result_offset = '0;
                        rsp_next.result_level  = '0;
                    end
                    else if (q_head.op == OP_ALLOC)
                    begin
                        state_next = BK_A_RD;
                    end
                    else
                    begin
                        state_next = BK_F_UP_RD;
                    end
                end
            end

            // Allocate: scan rows upward from the requested level.
            BK_A_RD:
            begin
                rd_row     = row_reg;
                state_next = BK_A_CHK;
            end

            BK_A_CHK:
            begin
                if (rdata != '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rdata & ~(ROW_W'(1) << pe);
                    if (k_reg == lvl)
                    begin
                        done_next              = 1'b1;
                        rsp_next.status        = ST_OK;
                        rsp_next.result_offset = alloc_off;
                        rsp_next.result_level  = RLVL_W'(lvl);
                        state_next             = BK_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - LW'(1);
                        g_next     = g_found << 1;
                        state_next = BK_A_SPLIT_RD;
                    end
                end
                else if (row_reg == last_row)
                begin
                    if (k_reg == LW'(LEVELS - 1))
                    begin
                        done_next              = 1'b1;
                        rsp_next.status        = ST_NO_MEM;
                        rsp_next.result_offset = '0;
                        rsp_next.result_level  = RLVL_W'(lvl);
                        state_next             = BK_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + LW'(1);
                        row_next   = '0;
                        state_next = BK_A_RD;
                    end
                end
                else
                begin
                    row_next   = row_reg + RIW'(1);
                    state_next = BK_A_RD;
                end
            end

            // Split: the upper half of each halved block becomes free.
            BK_A_SPLIT_RD:
            begin
                rd_row     = row_of(g_reg);
                state_next = BK_A_SPLIT_WR;
            end

            BK_A_SPLIT_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata | (ROW_W'(1) << bit_of(g_reg | GW'(1)));
                if (k_reg == lvl)
                begin
                    done_next              = 1'b1;
                    rsp_next.status        = ST_OK;
                    rsp_next.result_offset = alloc_off;
                    rsp_next.result_level  = RLVL_W'(lvl);
                    state_next             = BK_IDLE;
                end
                else
                begin
                    k_next     = k_reg - LW'(1);
                    g_next     = g_reg << 1;
                    state_next = BK_A_SPLIT_RD;
                end
            end

            // Free: look for a free block that already covers this one.
            BK_F_UP_RD:
            begin
                rd_row     = row_of(w_reg);
                state_next = BK_F_UP_CHK;
            end

            BK_F_UP_CHK:
            begin
                if (rdata[bit_of(w_reg)])
                begin
                    done_next              = 1'b1;
                    rsp_next.status        = ST_OK;
                    rsp_next.result_offset = '0;
                    rsp_next.result_level  = RLVL_W'(k_reg);
                    state_next             = BK_IDLE;
                end
                else if (k_reg != LW'(LEVELS - 1))
                begin
                    k_next     = k_reg + LW'(1);
                    w_next     = w_reg >> 1;
                    state_next = BK_F_UP_RD;
                end
                else if (lvl != '0)
                begin
                    k_next     = '0;
                    row_next   = row_of(GW'(lo_n));
                    state_next = BK_F_CLR_RD;
                end
                else
                begin
                    k_next     = lvl;
                    w_next     = g_reg;
                    state_next = (lvl == LW'(LEVELS - 1)) ? BK_F_SET_RD : BK_F_MRG_RD;
                end
            end

            // Clear free marks below the freed block, one row at a time.
            BK_F_CLR_RD:
            begin
                rd_row     = row_reg;
                state_next = BK_F_CLR_WR;
            end

            BK_F_CLR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = rdata & ~clr_mask;
                if (row_reg != row_of(GW'(hi_k - SPW'(1))))
                begin
                    row_next   = row_reg + RIW'(1);
                    state_next = BK_F_CLR_RD;
                end
                else if (k_reg + LW'(1) != lvl)
                begin
                    k_next     = k_reg + LW'(1);
                    row_next   = row_of(GW'(lo_n));
                    state_next = BK_F_CLR_RD;
                end
                else
                begin
                    k_next     = lvl;
                    w_next     = g_reg;
                    state_next = (lvl == LW'(LEVELS - 1)) ? BK_F_SET_RD : BK_F_MRG_RD;
                end
            end

            // Merge with the buddy while it is free.
            BK_F_MRG_RD:
            begin
                rd_row     = row_of(w_reg ^ GW'(1));
                state_next = BK_F_MRG_CHK;
            end

            BK_F_MRG_CHK:
            begin
                ram_we = 1'b1;
                if (rdata[bit_of(w_reg ^ GW'(1))])
                begin
                    ram_wdata  = rdata & ~(ROW_W'(1) << bit_of(w_reg ^ GW'(1)));
                    w_next     = w_reg >> 1;
                    k_next     = k_reg + LW'(1);
                    state_next = (k_reg + LW'(1) == LW'(LEVELS - 1)) ?
                                 BK_F_SET_RD : BK_F_MRG_RD;
                end
                else
                begin
                    // The buddy shares the row, so the mark goes in now.
                    ram_wdata              = rdata | (ROW_W'(1) << bit_of(w_reg));
                    done_next              = 1'b1;
                    rsp_next.status        = ST_OK;
                    rsp_next.result_offset = '0;
                    rsp_next.result_level  = RLVL_W'(k_reg);
                    state_next             = BK_IDLE;
                end
            end

            BK_F_SET_RD:
            begin
                rd_row     = row_of(w_reg);
                state_next = BK_F_SET_WR;
            end

            BK_F_SET_WR:
            begin
                ram_we                 = 1'b1;
                ram_wdata              = rdata | (ROW_W'(1) << bit_of(w_reg));
                done_next              = 1'b1;
                rsp_next.status        = ST_OK;
                rsp_next.result_offset = '0;
                rsp_next.result_level  = RLVL_W'(k_reg);
                state_next             = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            k_reg     <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Working values and the result word.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        row_reg  <= row_next;
        g_reg    <= g_next;
        w_reg    <= w_next;
        addr_reg <= ram_raddr;
        rsp_reg  <= rsp_next;
    end

    // A result is only ever issued on the way back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == BK_IDLE)
        else $error("result issued outside idle");

    // No result leaves while the map is being initialised.
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_CLEAR |-> !done_reg)
        else $error("result during map clearing");

    // The level cursor stays inside the tree.
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= LW'(LEVELS - 1))
        else $error("level cursor out of range");

    // The map is never written while waiting for a command.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_IDLE |-> !ram_we)
        else $error("map write while idle");

endmodule

>>> hw/rtl/buddy_block_allocator.sv
// Channel   | Handshake          | Word                  | Notes
// ----------+--------------------+-----------------------+------------------------------
// request   | start, busy        | req (bba_req_t)       | taken when start && !busy
// result    | done               | rsp (bba_rsp_t)       | one cycle, cannot be held off
// config    | cfg_we             | cfg_index, cfg_data   | written at once, no read-back
//
// After reset the free map is cleared by a pass of one row per cycle; busy is
// high for its length.
// An allocate reads map rows from the requested level up until one holds a free
// node, then splits down to the requested level; the single map port sets the pace.
// A free checks upward for a covering free block, clears any marks below it, merges
// with free buddies and sets its mark; rejected words are answered from idle.
// A two-word queue lets new requests in while the back end works.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int LEVELS     = LEVELS_DEF,
    parameter int TOP_BLOCKS = TOP_BLOCKS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bba_req_t             req,
    output logic                 done,
    output bba_rsp_t             rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HDR_W-1:0]     cfg_data
);

    logic [MBL_W-1:0] mbl_reg, mbl_next;
    logic [HDR_W-1:0] hdr_reg, hdr_next;
    bba_cmd_t         front_cmd;
    bba_cmd_t         q_head;
    logic             q_full, q_empty, q_pop;
    logic             clearing;
    logic             accept;

    // Configuration registers.
    always_comb
    begin
        mbl_next = mbl_reg;
        hdr_next = hdr_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_BLOCK_LOG2: mbl_next = cfg_data[MBL_W-1:0];
                CFG_HEADER_BYTES:   hdr_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbl_reg <= MBL_RESET;
            hdr_reg <= HDR_RESET;
        end
        else
        begin
            mbl_reg <= mbl_next;
            hdr_reg <= hdr_next;
        end
    end

    // Request acceptance.
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    bba_front #(
        .LEVELS     (LEVELS),
        .TOP_BLOCKS (TOP_BLOCKS)
    ) u_front (
        .req            (req),
        .min_block_log2 (mbl_reg),
        .header_bytes   (hdr_reg),
        .cmd            (front_cmd)
    );

    bba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    bba_back #(
        .LEVELS     (LEVELS),
        .TOP_BLOCKS (TOP_BLOCKS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .min_block_log2 (mbl_reg),
        .header_bytes   (hdr_reg),
        .clearing       (clearing),
        .done           (done),
        .rsp            (rsp)
    );

endmodule
